>>> sv/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared widths, register indexes and the position flag bundle of the
// 3x3 local maxima counter.
// ----------------------------------------------------------------------------
package lmc_pkg;

  localparam int ROW_W          = 16;  // row_count register
  localparam int COLUMN_COUNT_W = 11;  // column_count register
  localparam int CFG_DATA_W     = 16;  // widest register
  localparam int CFG_INDEX_W    = 1;
  localparam int COUNT_W        = 25;  // maxima_count

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_t;

  // Where the sample just accepted sits in the frame.
  typedef struct packed {
    logic r_ge1;     // row >= 1
    logic r_ge2;     // row >= 2
    logic c_ge1;     // column >= 1
    logic c_ge2;     // column >= 2
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

>>> sv/lmc_ram.sv
// ----------------------------------------------------------------------------
// lmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];  // read-first on a same-address write
    end
  end

endmodule

>>> sv/lmc_window.sv
// ----------------------------------------------------------------------------
// lmc_window
// 3x3 sample window, four peak judges and the running maxima count.
// ----------------------------------------------------------------------------
module lmc_window #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             restart,
  input  logic                             advance,
  input  lmc_pkg::pos_flags_t              flags,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic signed [SAMPLE_BITS-1:0]    upper_rd,
  input  logic signed [SAMPLE_BITS-1:0]    middle_rd,
  output logic [lmc_pkg::COUNT_W-1:0]      frame_total
);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  smp_t win      [3][3];
  smp_t win_next [3][3];
  logic [lmc_pkg::COUNT_W-1:0] running_count;
  logic [7:0] mask11, mask12, mask21, mask22;
  logic pk11, pk12, pk21, pk22;
  logic [2:0] found;

  // Strictly above every enabled neighbour.
  function automatic logic is_peak(input smp_t center, input smp_t nb [8],
                                   input logic [7:0] en);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (en[i] && (nb[i] >= center)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Window after this sample's shift; the judges look at it.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = upper_rd;
    win_next[1][2] = middle_rd;
    win_next[2][2] = sample;
  end

  // Neighbour order: NW N NE W E SW S SE of each center.
  always_comb begin
    mask11 = {1'b1, 1'b1, flags.c_ge2, 1'b1, flags.c_ge2,
              flags.r_ge2, flags.r_ge2, flags.r_ge2 & flags.c_ge2};
    mask12 = {1'b0, 1'b1, flags.c_ge1, 1'b0, flags.c_ge1,
              1'b0, flags.r_ge2, flags.r_ge2 & flags.c_ge1};
    mask21 = {3'b000, 1'b1, flags.c_ge2,
              flags.r_ge1, flags.r_ge1, flags.r_ge1 & flags.c_ge2};
    mask22 = {3'b000, 1'b0, flags.c_ge1,
              1'b0, flags.r_ge1, flags.r_ge1 & flags.c_ge1};

    pk11 = is_peak(win_next[1][1],
                   '{win_next[0][0], win_next[0][1], win_next[0][2], win_next[1][0],
                     win_next[1][2], win_next[2][0], win_next[2][1], win_next[2][2]},
                   mask11);
    pk12 = is_peak(win_next[1][2],
                   '{win_next[0][1], win_next[0][2], win_next[1][2], win_next[1][1],
                     win_next[1][2], win_next[2][1], win_next[2][2], win_next[1][2]},
                   mask12);
    pk21 = is_peak(win_next[2][1],
                   '{win_next[1][0], win_next[1][1], win_next[1][2], win_next[2][0],
                     win_next[2][2], win_next[2][1], win_next[2][1], win_next[2][1]},
                   mask21);
    pk22 = is_peak(win_next[2][2],
                   '{win_next[1][1], win_next[1][2], win_next[2][2], win_next[2][1],
                     win_next[2][2], win_next[2][2], win_next[2][2], win_next[2][2]},
                   mask22);

    found = 3'(pk11 & flags.r_ge1 & flags.c_ge1)
          + 3'(pk12 & flags.r_ge1 & flags.last_col)
          + 3'(pk21 & flags.last_row & flags.c_ge1)
          + 3'(pk22 & flags.last_row & flags.last_col);

    frame_total = running_count + lmc_pkg::COUNT_W'(found);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (restart) begin
      running_count <= '0;
    end else if (advance) begin
      win <= win_next;
      running_count <= (flags.last_row && flags.last_col) ? '0 : frame_total;
    end
  end

endmodule

>>> sv/local_maxima_counter_3x3.sv
// ----------------------------------------------------------------------------
// local_maxima_counter_3x3
// Counts strict eight-neighbour local maxima of a raster-order matrix and
// reports the count on the last sample of each frame.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload        | handshake
//  ----------+-----------+----------------+-----------------------------
//  sample    | in        | sample         | sample_valid / sample_stall
//  count     | out       | maxima_count   | count_valid / count_stall
//  config    | in        | cfg_index/data | cfg_write (no wait)
//
//  One sample per cycle sustained while sample_stall is low. The count
//  register and count_valid load as a frame's last sample leaves the judge
//  stage; the line buffer read and the judge stage load at its accepting edge.
//  rst (sync, active high) clears positions, count, window and valid flags;
//  the line buffers are not cleared, since rows above the frame are ignored.
//  Input stalls only when a frame-end sample sits in the judge stage while
//  the previous count transaction is still held by count_stall.
//  Any config write restarts the frame; write only while the block is idle.
// ----------------------------------------------------------------------------
module local_maxima_counter_3x3 #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  // count channel
  output logic                                count_valid,
  input  logic                                count_stall,
  output logic [lmc_pkg::COUNT_W-1:0]         maxima_count,
  // config port
  input  logic                                cfg_write,
  input  logic [lmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CMP_W = (COL_W + 1 > lmc_pkg::COLUMN_COUNT_W) ?
                         COL_W + 1 : lmc_pkg::COLUMN_COUNT_W;

  // Config registers
  logic [lmc_pkg::ROW_W-1:0]          row_count;
  logic [lmc_pkg::COLUMN_COUNT_W-1:0] column_count;

  // Raster position of the next sample
  logic [lmc_pkg::ROW_W-1:0] row_pos;
  logic [COL_W-1:0]          col_pos;
  logic [lmc_pkg::ROW_W-1:0] last_row_idx;
  logic [COL_W-1:0]          last_col_idx;
  logic [CMP_W-1:0]          cc_wide;
  lmc_pkg::pos_flags_t       pos_flags;

  // Judge stage (one sample behind the accepting edge)
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [COL_W-1:0]              s1_col;
  lmc_pkg::pos_flags_t           s1_flags;
  logic                          s1_fwd;
  logic signed [SAMPLE_BITS-1:0] fwd_upper;
  logic signed [SAMPLE_BITS-1:0] fwd_middle;

  logic signed [SAMPLE_BITS-1:0] upper_rd, middle_rd;
  logic signed [SAMPLE_BITS-1:0] upper_eff, middle_eff;
  logic [lmc_pkg::COUNT_W-1:0]   frame_total;

  logic accept, advance, out_free, s1_frame_end;

  // ---- handshake ----------------------------------------------------------
  assign out_free     = !count_valid || !count_stall;
  assign s1_frame_end = s1_flags.last_row && s1_flags.last_col;
  assign advance      = s1_valid && (!s1_frame_end || out_free);
  assign sample_stall = s1_valid && s1_frame_end && !out_free;
  assign accept       = sample_valid && !sample_stall;

  // ---- frame geometry -----------------------------------------------------
  // zero counts mean one; column count saturates at the buffer depth
  always_comb begin
    cc_wide = CMP_W'(column_count);
    if (column_count == '0) begin
      last_col_idx = '0;
    end else if (cc_wide > CMP_W'(MAX_COLUMNS)) begin
      last_col_idx = COL_W'(MAX_COLUMNS - 1);
    end else begin
      last_col_idx = COL_W'(cc_wide - CMP_W'(1));
    end
    last_row_idx = (row_count == '0) ? '0 : row_count - lmc_pkg::ROW_W'(1);

    pos_flags.r_ge1    = (row_pos != '0);
    pos_flags.r_ge2    = (row_pos > lmc_pkg::ROW_W'(1));
    pos_flags.c_ge1    = (col_pos != '0);
    pos_flags.c_ge2    = (COL_W'(col_pos) > COL_W'(1)) && (COL_W > 1);
    pos_flags.last_row = (row_pos == last_row_idx);
    pos_flags.last_col = (col_pos == last_col_idx);
  end

  // ---- config and position counters --------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= lmc_pkg::ROW_W'(1);
      column_count <= lmc_pkg::COLUMN_COUNT_W'(1);
      row_pos      <= '0;
      col_pos      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lmc_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_data[lmc_pkg::ROW_W-1:0];
        end
        lmc_pkg::REG_COLUMN_COUNT: begin
          column_count <= cfg_data[lmc_pkg::COLUMN_COUNT_W-1:0];
        end
        default: begin
        end
      endcase
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (pos_flags.last_col) begin
        col_pos <= '0;
        row_pos <= pos_flags.last_row ? '0 : row_pos + lmc_pkg::ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // ---- judge stage register ----------------------------------------------
  // A one-column frame reads the same buffer entry that the judge stage is
  // writing in that cycle; the written values are forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample  <= sample;
      s1_col     <= col_pos;
      s1_flags   <= pos_flags;
      s1_fwd     <= advance && (s1_col == col_pos);
      fwd_upper  <= middle_eff;
      fwd_middle <= s1_sample;
    end
  end

  assign upper_eff  = s1_fwd ? fwd_upper  : upper_rd;
  assign middle_eff = s1_fwd ? fwd_middle : middle_rd;

  // ---- line buffers -------------------------------------------------------
  lmc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_col),
    .wr_data (middle_eff),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (upper_rd)
  );

  lmc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_col),
    .wr_data (s1_sample),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (middle_rd)
  );

  // ---- window, judges, running count -------------------------------------
  lmc_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .advance     (advance),
    .flags       (s1_flags),
    .sample      (s1_sample),
    .upper_rd    (upper_eff),
    .middle_rd   (middle_eff),
    .frame_total (frame_total)
  );

  // ---- count output register ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (advance && s1_frame_end) begin
      count_valid <= 1'b1;
    end else if (out_free) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_frame_end) begin
      maxima_count <= frame_total;
    end
  end

endmodule

>>> sv/lmc_checker.sv
// ----------------------------------------------------------------------------
// lmc_checker
// Port-level checks of the 3x3 local maxima counter, bound to the top level.
// ----------------------------------------------------------------------------
module lmc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            sample_valid,
  input logic                            sample_stall,
  input logic signed [SAMPLE_BITS-1:0]   sample,
  input logic                            count_valid,
  input logic                            count_stall,
  input logic [lmc_pkg::COUNT_W-1:0]     maxima_count
);

  // held count transaction stays put
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid && $stable(maxima_count))
    else $error("count transaction changed while stalled");

  // stalled sample transaction is held by the sender
  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("sample transaction changed while stalled");

  // input backs up only behind a held count transaction
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> count_valid && count_stall)
    else $error("sample stalled without a held count");

  // no count straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !count_valid && !sample_stall)
    else $error("output valid right after reset");

  // non-adjacent maxima bound the count by the largest frame
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_valid |-> maxima_count <= lmc_pkg::COUNT_W'(16777216))
    else $error("maxima count out of range");

endmodule

bind local_maxima_counter_3x3 lmc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lmc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .count_valid  (count_valid),
  .count_stall  (count_stall),
  .maxima_count (maxima_count)
);
